[design/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, skipped while reset is active
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// a signal is low on the edge after reset was seen
`define ASSERT_RESET_LOW(lbl, clk, rst_n, sig, msg) \
    lbl: assert property (@(posedge clk) !rst_n |=> !sig) \
        else $error(msg);

`endif

[design/fp2h_pkg.sv]
// types and constants for the binary32 to binary16 converter
`default_nettype none

package fp2h_pkg;

    // operand class codes set by the front end
    typedef logic [2:0] t_cls;
    localparam t_cls CLS_ZERO = 3'd0;
    localparam t_cls CLS_SUB  = 3'd1;
    localparam t_cls CLS_NORM = 3'd2;
    localparam t_cls CLS_INF  = 3'd3;
    localparam t_cls CLS_NAN  = 3'd4;

    localparam logic [7:0]  EXP_SPECIAL   = 8'hff;
    localparam logic [7:0]  BIAS_DELTA    = 8'd112;   // 127 - 15
    localparam logic [7:0]  EXP_ZERO_LIM  = 8'd102;   // below this the value flushes to zero
    localparam logic [7:0]  SUB_SHIFT_REF = 8'd126;   // shift = 14 - (exp - 112)
    localparam logic [7:0]  HALF_EXP_MAX  = 8'd30;
    localparam logic [14:0] HALF_INF      = 15'h7c00;
    localparam logic [23:0] ROUND_HALF    = 24'h000fff;

    typedef struct packed {
        logic        sign;
        t_cls        cls;
        logic [7:0]  hexp;    // rebiased exponent, normal class
        logic [4:0]  shamt;   // right shift, subnormal class
        logic [22:0] mant;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

[design/fp2h_front.sv]
// front end: accepts binary32 items and classifies them
`default_nettype none

module fp2h_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire  [31:0]          i_float_bits,
    input  fp2h_pkg::t_qstat     i_qstat,
    output logic                 o_push,
    output fp2h_pkg::t_item      o_item
);

    logic            r_valid;
    fp2h_pkg::t_item r_item;
    fp2h_pkg::t_item n_item;
    logic            w_load;
    logic [7:0]      w_exp;
    logic [22:0]     w_mant;

    assign w_exp  = i_float_bits[30:23];
    assign w_mant = i_float_bits[22:0];

    always_comb begin
        n_item.sign  = i_float_bits[31];
        n_item.mant  = w_mant;
        n_item.hexp  = w_exp - fp2h_pkg::BIAS_DELTA;
        n_item.shamt = 5'(fp2h_pkg::SUB_SHIFT_REF - w_exp);
        if (w_exp == fp2h_pkg::EXP_SPECIAL) begin
            n_item.cls = (w_mant == 23'd0) ? fp2h_pkg::CLS_INF : fp2h_pkg::CLS_NAN;
        end else if (w_exp < fp2h_pkg::EXP_ZERO_LIM) begin
            n_item.cls = fp2h_pkg::CLS_ZERO;
        end else if (w_exp <= fp2h_pkg::BIAS_DELTA) begin
            n_item.cls = fp2h_pkg::CLS_SUB;
        end else begin
            n_item.cls = fp2h_pkg::CLS_NORM;
        end
    end

    assign w_load  = !r_valid || !i_qstat.full;
    assign o_stall = !w_load;
    assign o_push  = r_valid && !i_qstat.full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

[design/fp2h_queue.sv]
// short queue of classified items between front and back end
`default_nettype none

module fp2h_queue #(
    parameter int DEPTH = 2
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  fp2h_pkg::t_item      i_item,
    input  wire                  i_pop,
    output fp2h_pkg::t_qstat     o_qstat,
    output fp2h_pkg::t_item      o_item
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    fp2h_pkg::t_item r_mem [DEPTH];
    logic [PtrW-1:0] r_wptr;
    logic [PtrW-1:0] r_rptr;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;

    function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] ptr);
        logic [PtrW-1:0] res;
        if (ptr == PtrW'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + PtrW'(1);
        end
        return res;
    endfunction

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CntW'(1);
            2'b01:   n_count = r_count - CntW'(1);
            default: n_count = r_count;
        endcase
    end

    assign o_qstat.full  = (r_count == CntW'(DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_item        = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= ptr_next(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_next(r_rptr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

[design/fp2h_back.sv]
// back end: rounds classified items to binary16 and holds the result
`default_nettype none

module fp2h_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  fp2h_pkg::t_qstat     i_qstat,
    input  fp2h_pkg::t_item      i_item,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [15:0]          o_half_bits,
    output logic                 o_overflow_flag
);

    logic        r_valid;
    logic [15:0] r_half;
    logic        r_ovf;
    logic [15:0] n_half;
    logic        n_ovf;
    logic        w_load;

    // subnormal path
    logic [24:0] w_sub_mant;
    logic [24:0] w_sub_bias;
    logic [24:0] w_sub_low;
    logic [24:0] w_sub_sum;
    logic [24:0] w_sub_q;

    // normal path
    logic [23:0] w_rnd;
    logic        w_carry;
    logic [7:0]  w_exp;

    always_comb begin
        w_sub_mant = {2'b01, i_item.mant};
        w_sub_bias = (25'd1 << (i_item.shamt - 5'd1)) - 25'd1;
        w_sub_low  = w_sub_mant >> i_item.shamt;
        // ties to even: add one more when the kept lsb is odd
        w_sub_sum  = w_sub_mant + w_sub_bias + {24'd0, w_sub_low[0]};
        w_sub_q    = w_sub_sum >> i_item.shamt;

        w_rnd   = {1'b0, i_item.mant} + fp2h_pkg::ROUND_HALF + {23'd0, i_item.mant[13]};
        w_carry = w_rnd[23];
        w_exp   = i_item.hexp + {7'd0, w_carry};
    end

    always_comb begin
        n_ovf = 1'b0;
        unique case (i_item.cls)
            fp2h_pkg::CLS_SUB: begin
                n_half = {i_item.sign, w_sub_q[14:0]};
            end
            fp2h_pkg::CLS_NORM: begin
                if (w_exp > fp2h_pkg::HALF_EXP_MAX) begin
                    n_ovf  = 1'b1;
                    n_half = {i_item.sign, fp2h_pkg::HALF_INF};
                end else begin
                    n_half = {i_item.sign, w_exp[4:0], w_carry ? 10'd0 : w_rnd[22:13]};
                end
            end
            fp2h_pkg::CLS_INF: begin
                n_half = {i_item.sign, fp2h_pkg::HALF_INF};
            end
            fp2h_pkg::CLS_NAN: begin
                // keep the payload, but never let it collapse to infinity
                n_half = {i_item.sign, fp2h_pkg::HALF_INF[14:10], i_item.mant[22:14],
                          i_item.mant[13] | (i_item.mant[22:13] == 10'd0)};
            end
            default: begin
                n_half = {i_item.sign, 15'd0};
            end
        endcase
    end

    assign w_load = !r_valid || !i_stall;
    assign o_pop  = w_load && !i_qstat.empty;

    assign o_valid         = r_valid;
    assign o_half_bits     = r_half;
    assign o_overflow_flag = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= !i_qstat.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_half <= n_half;
            r_ovf  <= n_ovf;
        end
    end

endmodule

`default_nettype wire

[design/float32_to_float16_convert_unit.sv]
// top level of the binary32 to binary16 converter
// usage:
//   input channel: i_valid / o_stall carry one binary32 pattern per item on
//   i_float_bits; an item is taken on a rising edge with i_valid high and
//   o_stall low
//   output channel: o_valid / i_stall carry o_half_bits (round to nearest
//   even) and o_overflow_flag (finite input that became half infinity)
//   throughput: one item per cycle while o_stall is low; each item is
//   classified in the front register, waits in a QUEUE_DEPTH entry queue
//   and is rounded into the output register
//   stall: the output register holds its item while i_stall is high; the
//   queue and the front register keep taking items until both are full,
//   then o_stall rises
//   reset: synchronous, active low on i_rst_n; it empties the queue and
//   clears both valid flags, items in flight are dropped
`default_nettype none

module float32_to_float16_convert_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [31:0] i_float_bits,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [15:0] o_half_bits,
    output logic        o_overflow_flag
);

    fp2h_pkg::t_item  w_front_item;
    fp2h_pkg::t_item  w_head_item;
    fp2h_pkg::t_qstat w_qstat;
    logic             w_push;
    logic             w_pop;

    fp2h_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_float_bits (i_float_bits),
        .i_qstat      (w_qstat),
        .o_push       (w_push),
        .o_item       (w_front_item)
    );

    fp2h_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_qstat (w_qstat),
        .o_item  (w_head_item)
    );

    fp2h_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_qstat         (w_qstat),
        .i_item          (w_head_item),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_half_bits     (o_half_bits),
        .o_overflow_flag (o_overflow_flag)
    );

endmodule

`default_nettype wire

[design/fp2h_checker.sv]
// port level checks for the converter, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module fp2h_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_stall,
    input wire [31:0] i_float_bits,
    input wire        o_valid,
    input wire        i_stall,
    input wire [15:0] o_half_bits,
    input wire        o_overflow_flag
);

    `ASSERT_RESET_LOW(a_out_idle_after_reset, i_clk, i_rst_n, o_valid, "o_valid high after reset")
    `ASSERT_SYNC(a_out_valid_held, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "o_valid dropped while stalled")
    `ASSERT_SYNC(a_out_data_held, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_half_bits) && $stable(o_overflow_flag), "output item changed while stalled")
    `ASSERT_SYNC(a_ovf_is_inf, i_clk, i_rst_n, o_valid && o_overflow_flag |-> o_half_bits[14:0] == 15'h7c00, "overflow item is not infinity")
    `ASSERT_SYNC(a_in_data_held, i_clk, i_rst_n, i_valid && o_stall |=> i_valid && $stable(i_float_bits), "stalled input item changed")

endmodule

bind float32_to_float16_convert_unit fp2h_checker u_fp2h_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_float_bits    (i_float_bits),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_half_bits     (o_half_bits),
    .o_overflow_flag (o_overflow_flag)
);

`default_nettype wire
